// ----- hw/rtl/etrb_pkg.sv -----
// Shared types, codes and widths for the event trace ring buffer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package etrb_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 10;
    localparam int CMD_W       = 3;
    localparam int ENTRY_W     = 13;
    localparam int RECORD_W    = 4 * WORD_W;
    localparam int S_TDATA_W   = 144;
    localparam int M_TDATA_W   = 144;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD   = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_RESET    = 3'd3,
        CMD_WRAP_ON  = 3'd4,
        CMD_WRAP_OFF = 3'd5,
        CMD_READ     = 3'd6,
        CMD_COUNT    = 3'd7
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic load_ram;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
    } dp_status_t;

endpackage

// ----- hw/rtl/etrb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module etrb_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/etrb_ctrl.sv -----
// Controller: input/output handshake and read sequencing.
// Depends on etrb_pkg.
`timescale 1ns / 1ps

module etrb_ctrl import etrb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        exec;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign exec     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (exec && status.is_read) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.exec       = exec;
        cmd.load_ram   = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (exec && !status.is_read) begin
                    out_valid_next = 1'b1;
                end
            end
            ST_READ: begin
                cmd.load_ram   = 1'b1;
                out_valid_next = 1'b1;
            end
            default: out_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/etrb_dp.sv -----
// Datapath: trace state, record store, read address and result registers.
// Depends on etrb_pkg and etrb_ram.
`timescale 1ns / 1ps

module etrb_dp import etrb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                command,
    input  logic [WORD_W-1:0]   time_stamp,
    input  logic [WORD_W-1:0]   word_one,
    input  logic [WORD_W-1:0]   word_two,
    input  logic [WORD_W-1:0]   word_three,
    input  logic [POS_W-1:0]    read_position,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    output logic                read_valid,
    output logic [WORD_W-1:0]   out_time,
    output logic [WORD_W-1:0]   out_one,
    output logic [WORD_W-1:0]   out_two,
    output logic [WORD_W-1:0]   out_three,
    output logic [ENTRY_W-1:0]  entry_words,
    output logic                is_enabled,
    output logic                has_wrapped
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             enabled_reg, enabled_next;
    logic             wrap_ok_reg, wrap_ok_next;
    logic             wrapped_reg, wrapped_next;

    logic             hit_reg;
    logic [WORD_W-1:0] time_reg, one_reg, two_reg, three_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic             en_out_reg, wrap_out_reg;

    logic             do_write, do_read, hit;
    logic [IDX_W-1:0] wr_idx_inc, recs;
    logic [SUM_W-1:0] pos_ext, limit, sum, phys;
    logic [IDX_W+14:0] words_ext;
    logic [RECORD_W-1:0] rdata;

    assign status.is_read = (command == CMD_READ);

    assign do_write   = cmd.exec && (command == CMD_RECORD) && enabled_reg
                        && (wr_idx_reg != DEPTH_IDX);
    assign do_read    = cmd.exec && (command == CMD_READ);
    assign wr_idx_inc = wr_idx_reg + IDX_W'(1);

    always_comb begin
        wr_idx_next  = wr_idx_reg;
        enabled_next = enabled_reg;
        wrap_ok_next = wrap_ok_reg;
        wrapped_next = wrapped_reg;
        unique case (command)
            CMD_RECORD: begin
                if (do_write) begin
                    wr_idx_next = wr_idx_inc;
                    if (wr_idx_inc == DEPTH_IDX) begin
                        if (wrap_ok_reg) begin
                            wr_idx_next  = '0;
                            wrapped_next = 1'b1;
                        end else begin
                            enabled_next = 1'b0;
                        end
                    end
                end
            end
            CMD_START:    enabled_next = 1'b1;
            CMD_STOP:     enabled_next = 1'b0;
            CMD_RESET: begin
                wr_idx_next  = '0;
                wrapped_next = 1'b0;
            end
            CMD_WRAP_ON:  wrap_ok_next = 1'b1;
            CMD_WRAP_OFF: begin
                wrap_ok_next = 1'b0;
                wrapped_next = 1'b0;
            end
            CMD_READ, CMD_COUNT: ;
            default: ;
        endcase
    end

    // logical to physical record, oldest first once wrapped
    always_comb begin
        pos_ext = SUM_W'(read_position);
        limit   = wrapped_reg ? DEPTH_SUM : SUM_W'(wr_idx_reg);
        hit     = pos_ext < limit;
        sum     = SUM_W'(wr_idx_reg) + pos_ext;
        if (!wrapped_reg) begin
            phys = pos_ext;
        end else if (sum >= DEPTH_SUM) begin
            phys = sum - DEPTH_SUM;
        end else begin
            phys = sum;
        end
    end

    assign recs      = wrapped_next ? DEPTH_IDX : wr_idx_next;
    assign words_ext = {13'd0, recs, 2'b00};

    etrb_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (wr_idx_reg[ADDR_W-1:0]),
        .wdata ({word_three, word_two, word_one, time_stamp}),
        .re    (do_read),
        .raddr (phys[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            enabled_reg <= 1'b0;
            wrap_ok_reg <= 1'b1;
            wrapped_reg <= 1'b0;
        end else if (cmd.exec) begin
            wr_idx_reg  <= wr_idx_next;
            enabled_reg <= enabled_next;
            wrap_ok_reg <= wrap_ok_next;
            wrapped_reg <= wrapped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            hit_reg      <= do_read && hit;
            entry_reg    <= words_ext[ENTRY_W-1:0];
            en_out_reg   <= enabled_next;
            wrap_out_reg <= wrapped_next;
            time_reg     <= '0;
            one_reg      <= '0;
            two_reg      <= '0;
            three_reg    <= '0;
        end else if (cmd.load_ram && hit_reg) begin
            time_reg     <= rdata[WORD_W-1:0];
            one_reg      <= rdata[2*WORD_W-1:WORD_W];
            two_reg      <= rdata[3*WORD_W-1:2*WORD_W];
            three_reg    <= rdata[4*WORD_W-1:3*WORD_W];
        end
    end

    assign read_valid  = hit_reg;
    assign out_time    = time_reg;
    assign out_one     = one_reg;
    assign out_two     = two_reg;
    assign out_three   = three_reg;
    assign entry_words = entry_reg;
    assign is_enabled  = en_out_reg;
    assign has_wrapped = wrap_out_reg;

endmodule

// ----- hw/rtl/event_trace_ring_buffer_top.sv -----
// Event trace ring buffer top level: stream ports, controller and datapath.
// Most results are registered in the cycle after accept; a read passes the
// store's read register, then the result registers. Throughput: one item per
// cycle unless m_tready stalls the output; a read holds off the next input.
// Reset (aresetn low, synchronous): index zero, recording off, wrap on,
// wrapped clear, no result pending; record store contents are kept.
`timescale 1ns / 1ps

module event_trace_ring_buffer_top import etrb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // time_stamp, word_one, word_two, word_three, read_position, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_time, out_one, out_two, out_three, entry_words, is_enabled,
    // has_wrapped, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // read_valid
    output logic                 m_tuser
);

    ctrl_cmd_t    cmd;
    dp_status_t   status;
    logic [WORD_W-1:0]  out_time, out_one, out_two, out_three;
    logic [ENTRY_W-1:0] entry_words;
    logic               is_enabled, has_wrapped;

    etrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    etrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .command       (cmd_t'(s_tuser)),
        .time_stamp    (s_tdata[WORD_W-1:0]),
        .word_one      (s_tdata[2*WORD_W-1:WORD_W]),
        .word_two      (s_tdata[3*WORD_W-1:2*WORD_W]),
        .word_three    (s_tdata[4*WORD_W-1:3*WORD_W]),
        .read_position (s_tdata[4*WORD_W+POS_W-1:4*WORD_W]),
        .cmd           (cmd),
        .status        (status),
        .read_valid    (m_tuser),
        .out_time      (out_time),
        .out_one       (out_one),
        .out_two       (out_two),
        .out_three     (out_three),
        .entry_words   (entry_words),
        .is_enabled    (is_enabled),
        .has_wrapped   (has_wrapped)
    );

    assign m_tdata = {1'b0, has_wrapped, is_enabled, entry_words,
                      out_three, out_two, out_one, out_time};

endmodule
